// ===== hdl/rsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsoc_pkg
// Shared types and constants for the ray/segment obstruction check.
// ----------------------------------------------------------------------------
`default_nettype none

package rsoc_pkg;

    localparam int MAX_LINES_DEF  = 64;
    localparam int COORD_FRAC_DEF = 12;
    localparam int T_BITS         = 30;   // ray parameter, unsigned Q1.30
    localparam int DIV_W          = 68;   // cross product width
    localparam int CFG_W          = 7;

    // table kinds
    localparam logic [1:0] KIND_CEIL  = 2'd0;
    localparam logic [1:0] KIND_LWALL = 2'd1;
    localparam logic [1:0] KIND_RWALL = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CEIL_COUNT  = 2'd0;
    localparam logic [1:0] CFG_LWALL_COUNT = 2'd1;
    localparam logic [1:0] CFG_RWALL_COUNT = 2'd2;

    // check mask bits
    localparam int MASK_CEIL  = 1;
    localparam int MASK_LWALL = 2;
    localparam int MASK_RWALL = 3;

    // item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [1:0]         line_kind;
        logic [5:0]         line_slot;
        logic signed [31:0] point_ax;
        logic signed [31:0] point_ay;
        logic signed [31:0] point_bx;
        logic signed [31:0] point_by;
        logic signed [15:0] joint_tag;
        logic [3:0]         check_mask;
    } t_in;

    typedef struct packed {
        logic any_hit;
        logic blocked;
    } t_out;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [15:0] joint;
    } t_seg;

    typedef enum logic [1:0] {
        PATH_GEN,
        PATH_HORZ,
        PATH_VERT
    } t_path;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KIND,
        ST_READ,
        ST_DECODE,
        ST_ROUTE,
        ST_MUL,
        ST_NORM,
        ST_RANGE,
        ST_DIV,
        ST_SCALE,
        ST_POINT,
        ST_DIST,
        ST_SQUARE,
        ST_COMPARE,
        ST_NEXT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/ray_segment_obstruction_check.sv =====
// ----------------------------------------------------------------------------
// ray_segment_obstruction_check
// Closest-hit search of a ray against three stored segment tables.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on i_item when i_start is high and o_busy is low. A load item
//   (mode 0) writes one segment into the table memory in that cycle and gives
//   no result; o_busy stays low. A query item (mode 1) walks every enabled
//   table entry by entry and ends with one result on o_result, marked by
//   o_valid for exactly one cycle; the receiver cannot stall it.
//   Table counts are written on the i_cfg_* channel (always ready); the user
//   writes them while the block is idle, which the block does not enforce.
// Query sequence:
//   For each searched entry a query reads the table, then on the general
//   cross path forms the cross products on the one shared multiplier, waits
//   on the bit-serial division, scales, forms the squared distance and
//   compares; an entry that misses early ends sooner. A query searches up
//   to 192 entries, and no new item is taken while o_busy is high. The
//   single table memory port and the serial divider set the query time.
// Reset:
//   Counts clear to zero and the sequencer goes idle; the table memory is
//   not cleared and an entry must be loaded before a count covers it.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_segment_obstruction_check
    import rsoc_pkg::*;
#(
    parameter int MAX_LINES_PER_KIND = MAX_LINES_DEF,
    parameter int COORD_FRAC_BITS    = COORD_FRAC_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_in              i_item,
    output logic                  o_busy,
    output logic                  o_valid,
    output t_out                  o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int DEPTH       = 3 * MAX_LINES_PER_KIND;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(MAX_LINES_PER_KIND + 1);
    localparam int AXIS_THRESH = (1 << COORD_FRAC_BITS) / 10000;
    localparam int END_TOL     = (1 << COORD_FRAC_BITS) / 10;
    localparam logic signed [32:0] THR33 = 33'(AXIS_THRESH);
    localparam logic signed [34:0] TOL35 = 35'(END_TOL);

    // ---------------- state ----------------
    t_state r_state, n_state;
    logic [2:0]       r_step;
    logic [1:0]       r_kind;
    logic [CNT_W-1:0] r_idx;
    logic [CFG_W-1:0] r_cnt_ceil, r_cnt_lwall, r_cnt_rwall;

    logic signed [31:0] r_ax, r_ay, r_bx, r_by;
    logic signed [32:0] r_rx, r_ry;
    logic signed [15:0] r_ledge;
    logic [3:0]         r_mask;
    logic               r_found, r_same;
    logic [63:0]        r_best;

    t_seg               r_rd;
    t_seg               mem [DEPTH];
    logic signed [32:0] r_sx, r_sy, r_qx, r_qy;
    logic signed [31:0] r_lo, r_hi;
    t_path              r_path;

    logic signed [67:0] r_den, r_tn, r_un, r_prod;
    logic [T_BITS:0]    r_t;
    logic signed [33:0] r_offx, r_offy, r_ix, r_iy, r_dx, r_dy;
    logic [63:0]        r_sqa, r_sqb;

    // ---------------- control outputs ----------------
    logic rd_en, wr_en, div_start, div_busy, div_done;
    logic [DIV_W-1:0]  div_num, div_den;
    logic [T_BITS:0]   div_quot;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    // ---------------- entry count of current table ----------------
    logic [CFG_W-1:0] cnt_sel;
    logic [CNT_W-1:0] n_eff;
    logic             kind_en;

    always_comb begin
        unique case (r_kind)
            KIND_CEIL:  cnt_sel = r_cnt_ceil;
            KIND_LWALL: cnt_sel = r_cnt_lwall;
            KIND_RWALL: cnt_sel = r_cnt_rwall;
            default:    cnt_sel = '0;
        endcase
        n_eff = (32'(cnt_sel) > 32'(MAX_LINES_PER_KIND)) ?
                CNT_W'(MAX_LINES_PER_KIND) : CNT_W'(cnt_sel);
        unique case (r_kind)
            KIND_CEIL:  kind_en = r_mask[MASK_CEIL] && (r_ay <= r_by);
            KIND_LWALL: kind_en = r_mask[MASK_LWALL] && (r_ax <= r_bx);
            KIND_RWALL: kind_en = r_mask[MASK_RWALL] && (r_ax >= r_bx);
            default:    kind_en = 1'b0;
        endcase
        kind_en = kind_en && (n_eff != '0);
    end

    // ---------------- addresses ----------------
    function automatic logic [ADDR_W-1:0] kind_base(input logic [1:0] k);
        logic [ADDR_W-1:0] b;
        unique case (k)
            KIND_LWALL: b = ADDR_W'(MAX_LINES_PER_KIND);
            KIND_RWALL: b = ADDR_W'(2 * MAX_LINES_PER_KIND);
            default:    b = '0;
        endcase
        return b;
    endfunction

    assign rd_addr = kind_base(r_kind) + ADDR_W'(r_idx);
    assign wr_addr = kind_base(i_item.line_kind) + ADDR_W'(i_item.line_slot);
    assign wr_en   = i_start && !o_busy && (i_item.mode == MODE_LOAD) &&
                     (i_item.line_kind != KIND_NONE) &&
                     (32'(i_item.line_slot) < 32'(MAX_LINES_PER_KIND));

    // ---------------- table memory ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= '{x0: i_item.point_ax, y0: i_item.point_ay,
                              x1: i_item.point_bx, y1: i_item.point_by,
                              joint: i_item.joint_tag};
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // ---------------- route decision for near-axis lines ----------------
    logic               rt_near, rt_degen, rt_dhit, rt_div_ok;
    logic signed [32:0] rt_axis;
    logic signed [33:0] rt_vnum, rt_vden;

    always_comb begin
        rt_axis = (r_kind == KIND_CEIL) ? r_sy : r_sx;
        rt_near = (rt_axis <= THR33) && (rt_axis >= -THR33);
        rt_vnum = r_rx[32] ? -34'(r_qx) : 34'(r_qx);
        rt_vden = r_rx[32] ? -34'(r_rx) : 34'(r_rx);
        if (r_kind == KIND_CEIL) begin
            rt_degen  = (r_ry == '0);
            rt_dhit   = (r_qy == '0) && (r_ax >= r_lo) && (r_ax <= r_hi);
            rt_div_ok = !r_qy[32] && (r_by >= r_rd.y0);
        end else begin
            rt_degen  = (r_rx == '0);
            rt_dhit   = (r_qx == '0) && (r_ay >= r_lo) && (r_ay <= r_hi);
            rt_div_ok = !rt_vnum[33] && (rt_vnum <= rt_vden);
        end
    end

    // ---------------- divider operands ----------------
    always_comb begin
        if (r_state == ST_RANGE) begin
            div_num = DIV_W'(r_tn);
            div_den = DIV_W'(r_den);
        end else if (r_kind == KIND_CEIL) begin
            div_num = DIV_W'(r_qy);
            div_den = DIV_W'(r_ry);
        end else begin
            div_num = DIV_W'(rt_vnum);
            div_den = DIV_W'(rt_vden);
        end
    end

    rsoc_frac_div #(.W(DIV_W), .QW(T_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ---------------- shared multiplier ----------------
    logic signed [33:0] op_a, op_b, mag_rx, mag_ry;
    logic signed [33:0] t_ext;

    always_comb begin
        mag_rx = r_rx[32] ? -34'(r_rx) : 34'(r_rx);
        mag_ry = r_ry[32] ? -34'(r_ry) : 34'(r_ry);
        t_ext  = 34'({1'b0, r_t});
        op_a   = '0;
        op_b   = '0;
        unique case (r_state)
            ST_MUL: begin
                unique case (r_step)
                    3'd0:    begin op_a = 34'(r_rx); op_b = 34'(r_sy); end
                    3'd1:    begin op_a = 34'(r_ry); op_b = 34'(r_sx); end
                    3'd2:    begin op_a = 34'(r_qx); op_b = 34'(r_sy); end
                    3'd3:    begin op_a = 34'(r_qy); op_b = 34'(r_sx); end
                    3'd4:    begin op_a = 34'(r_qx); op_b = 34'(r_ry); end
                    3'd5:    begin op_a = 34'(r_qy); op_b = 34'(r_rx); end
                    default: begin op_a = '0; op_b = '0; end
                endcase
            end
            ST_SCALE: begin
                if (r_step == 3'd0) begin
                    op_a = mag_rx; op_b = t_ext;
                end else if (r_step == 3'd1) begin
                    op_a = mag_ry; op_b = t_ext;
                end
            end
            ST_SQUARE: begin
                if (r_step == 3'd0) begin
                    op_a = r_dx; op_b = r_dx;
                end else if (r_step == 3'd1) begin
                    op_a = r_dy; op_b = r_dy;
                end
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    // ---------------- intersection point of near-axis lines ----------------
    logic signed [34:0] pt_v, pt_lo, pt_hi, pt_c;
    logic               pt_ok;
    logic signed [33:0] scl_off;

    always_comb begin
        if (r_path == PATH_HORZ) begin
            pt_v = 35'(r_ax) + 35'(r_offx);
        end else begin
            pt_v = 35'(r_ay) + 35'(r_offy);
        end
        pt_lo = 35'(r_lo);
        pt_hi = 35'(r_hi);
        pt_ok = (pt_v >= pt_lo - TOL35) && (pt_v <= pt_hi + TOL35);
        if (pt_v < pt_lo) begin
            pt_c = pt_lo;
        end else if (pt_v > pt_hi) begin
            pt_c = pt_hi;
        end else begin
            pt_c = pt_v;
        end
        // truncate toward zero, then restore the sign of the offset
        scl_off = 34'({1'b0, r_prod[62:T_BITS]});
    end

    // ---------------- distance compare ----------------
    logic [64:0] sum_d;
    logic [63:0] sq_dist;

    always_comb begin
        sum_d   = {1'b0, r_sqa} + {1'b0, r_sqb};
        sq_dist = sum_d[64] ? '1 : sum_d[63:0];
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_item.mode == MODE_QUERY) n_state = ST_KIND;
            end
            ST_KIND: begin
                if (r_kind == KIND_NONE) n_state = ST_DONE;
                else if (kind_en)        n_state = ST_READ;
            end
            ST_READ:   n_state = ST_DECODE;
            ST_DECODE: n_state = ST_ROUTE;
            ST_ROUTE: begin
                if (!rt_near)      n_state = ST_MUL;
                else if (rt_degen) n_state = rt_dhit ? ST_DIST : ST_NEXT;
                else               n_state = rt_div_ok ? ST_DIV : ST_NEXT;
            end
            ST_MUL: begin
                if (r_step == 3'd6) n_state = ST_NORM;
            end
            ST_NORM:  n_state = (r_den == '0) ? ST_NEXT : ST_RANGE;
            ST_RANGE: begin
                if (r_tn < 0 || r_un < 0 || r_tn > r_den || r_un > r_den) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (r_step == 3'd2) n_state = ST_POINT;
            end
            ST_POINT: begin
                if (r_path == PATH_GEN || pt_ok) n_state = ST_DIST;
                else                             n_state = ST_NEXT;
            end
            ST_DIST: n_state = ST_SQUARE;
            ST_SQUARE: begin
                if (r_step == 3'd2) n_state = ST_COMPARE;
            end
            ST_COMPARE: n_state = ST_NEXT;
            ST_NEXT: begin
                n_state = (32'(r_idx) + 1 < 32'(n_eff)) ? ST_READ : ST_KIND;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_busy    = (r_state != ST_IDLE);
        o_valid   = (r_state == ST_DONE);
        rd_en     = (r_state == ST_READ);
        div_start = ((r_state == ST_ROUTE) && rt_near && !rt_degen && rt_div_ok) ||
                    ((r_state == ST_RANGE) && (n_state == ST_DIV));
    end

    assign o_cfg_ready      = 1'b1;
    assign o_result.any_hit = r_found;
    assign o_result.blocked = r_found && !r_same;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_ceil  <= '0;
            r_cnt_lwall <= '0;
            r_cnt_rwall <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CEIL_COUNT:  r_cnt_ceil  <= i_cfg_data;
                CFG_LWALL_COUNT: r_cnt_lwall <= i_cfg_data;
                CFG_RWALL_COUNT: r_cnt_rwall <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_kind  <= KIND_CEIL;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_same  <= 1'b0;
        end else begin
            r_state <= n_state;
            // step counter runs inside multi-cycle states
            if (n_state != r_state) r_step <= '0;
            else                    r_step <= r_step + 3'd1;
            unique case (r_state)
                ST_IDLE: begin
                    if (n_state == ST_KIND) begin
                        r_kind  <= KIND_CEIL;
                        r_found <= 1'b0;
                        r_same  <= 1'b0;
                    end
                end
                ST_KIND: begin
                    if (r_kind != KIND_NONE) begin
                        if (kind_en) r_idx  <= '0;
                        else         r_kind <= r_kind + 2'd1;
                    end
                end
                ST_COMPARE: begin
                    if (!r_found || sq_dist < r_best) begin
                        r_found <= 1'b1;
                        r_same  <= (r_rd.joint == r_ledge);
                    end
                end
                ST_NEXT: begin
                    if (n_state == ST_READ) r_idx  <= r_idx + CNT_W'(1);
                    else                    r_kind <= r_kind + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ax    <= i_item.point_ax;
                r_ay    <= i_item.point_ay;
                r_bx    <= i_item.point_bx;
                r_by    <= i_item.point_by;
                r_rx    <= 33'(i_item.point_bx) - 33'(i_item.point_ax);
                r_ry    <= 33'(i_item.point_by) - 33'(i_item.point_ay);
                r_ledge <= i_item.joint_tag;
                r_mask  <= i_item.check_mask;
            end
            ST_DECODE: begin
                r_sx <= 33'(r_rd.x1) - 33'(r_rd.x0);
                r_sy <= 33'(r_rd.y1) - 33'(r_rd.y0);
                r_qx <= 33'(r_rd.x0) - 33'(r_ax);
                r_qy <= 33'(r_rd.y0) - 33'(r_ay);
                if (r_kind == KIND_CEIL) begin
                    r_lo <= (r_rd.x0 < r_rd.x1) ? r_rd.x0 : r_rd.x1;
                    r_hi <= (r_rd.x0 < r_rd.x1) ? r_rd.x1 : r_rd.x0;
                end else begin
                    r_lo <= (r_rd.y0 < r_rd.y1) ? r_rd.y0 : r_rd.y1;
                    r_hi <= (r_rd.y0 < r_rd.y1) ? r_rd.y1 : r_rd.y0;
                end
            end
            ST_ROUTE: begin
                if (!rt_near) begin
                    r_path <= PATH_GEN;
                end else if (r_kind == KIND_CEIL) begin
                    r_path <= PATH_HORZ;
                    r_ix   <= 34'(r_ax);
                    r_iy   <= 34'(r_rd.y0);
                end else begin
                    r_path <= PATH_VERT;
                    r_ix   <= 34'(r_rd.x0);
                    r_iy   <= 34'(r_ay);
                end
            end
            ST_MUL: begin
                // accumulate the product issued in the previous step
                unique case (r_step)
                    3'd1:    r_den <= r_prod;
                    3'd2:    r_den <= r_den - r_prod;
                    3'd3:    r_tn  <= r_prod;
                    3'd4:    r_tn  <= r_tn - r_prod;
                    3'd5:    r_un  <= r_prod;
                    3'd6:    r_un  <= r_un - r_prod;
                    default: ;
                endcase
            end
            ST_NORM: begin
                if (r_den < 0) begin
                    r_den <= -r_den;
                    r_tn  <= -r_tn;
                    r_un  <= -r_un;
                end
            end
            ST_DIV: begin
                if (div_done) r_t <= div_quot;
            end
            ST_SCALE: begin
                if (r_step == 3'd1) r_offx <= r_rx[32] ? -scl_off : scl_off;
                if (r_step == 3'd2) r_offy <= r_ry[32] ? -scl_off : scl_off;
            end
            ST_POINT: begin
                unique case (r_path)
                    PATH_GEN: begin
                        r_ix <= 34'(r_ax) + r_offx;
                        r_iy <= 34'(r_ay) + r_offy;
                    end
                    PATH_HORZ: r_ix <= 34'(pt_c);
                    PATH_VERT: r_iy <= 34'(pt_c);
                    default: ;
                endcase
            end
            ST_DIST: begin
                r_dx <= r_ix - 34'(r_ax);
                r_dy <= r_iy - 34'(r_ay);
            end
            ST_SQUARE: begin
                if (r_step == 3'd1) r_sqa <= r_prod[63:0];
                if (r_step == 3'd2) r_sqb <= r_prod[63:0];
            end
            ST_COMPARE: begin
                if (!r_found || sq_dist < r_best) r_best <= sq_dist;
            end
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy)
        else $error("result strobe not followed by idle");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (div_busy || div_done))
        else $error("waiting on a divider that was not started");

    a_decode_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECODE) |-> $past(r_state == ST_READ))
        else $error("entry decoded without a memory read");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ===== hdl/rsoc_frac_div.sv =====
// ----------------------------------------------------------------------------
// rsoc_frac_div
// Restoring divider: floor(num * 2^QW / den) for num <= den, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsoc_frac_div
    import rsoc_pkg::*;
#(
    parameter int W  = DIV_W,
    parameter int QW = T_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [W-1:0]  i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic [QW:0]        o_quot
);

    localparam int CW = $clog2(QW + 1);

    logic [W:0]    r_rem;
    logic [W-1:0]  r_den;
    logic [QW:0]   r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          take;

    // trial subtract of the shifted remainder
    always_comb begin
        shifted = {r_rem[W-1:0], 1'b0};
        diff    = shifted - {1'b0, r_den};
        take    = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_rem <= {1'b0, i_num};
                if (i_num >= i_den) begin
                    // whole ray: saturate at one
                    r_q    <= (QW + 1)'(1) << QW;
                    r_done <= 1'b1;
                end else begin
                    r_q    <= '0;
                    r_cnt  <= CW'(QW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= take ? diff : shifted;
                r_q   <= {r_q[QW-1:0], take};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire
